@@ src/cpualu_pkg.sv @@
// cpualu_pkg: request/response types, flag type and operation codes of the cpu alu
`timescale 1ns / 1ps

package cpualu_pkg;

    // operation codes carried in the mode field
    localparam logic [4:0] MODE_ADD       = 5'd0;
    localparam logic [4:0] MODE_ADC       = 5'd1;
    localparam logic [4:0] MODE_SUB       = 5'd2;
    localparam logic [4:0] MODE_SBC       = 5'd3;
    localparam logic [4:0] MODE_AND       = 5'd4;
    localparam logic [4:0] MODE_XOR       = 5'd5;
    localparam logic [4:0] MODE_OR        = 5'd6;
    localparam logic [4:0] MODE_CP        = 5'd7;
    localparam logic [4:0] MODE_INC8      = 5'd8;
    localparam logic [4:0] MODE_DEC8      = 5'd9;
    localparam logic [4:0] MODE_INC16     = 5'd10;
    localparam logic [4:0] MODE_DEC16     = 5'd11;
    localparam logic [4:0] MODE_ADDHL     = 5'd12;
    localparam logic [4:0] MODE_ADDSP     = 5'd13;
    localparam logic [4:0] MODE_RLCA      = 5'd14;
    localparam logic [4:0] MODE_RRCA      = 5'd15;
    localparam logic [4:0] MODE_RLC       = 5'd16;
    localparam logic [4:0] MODE_RRC       = 5'd17;
    localparam logic [4:0] MODE_RL        = 5'd18;
    localparam logic [4:0] MODE_RR        = 5'd19;
    localparam logic [4:0] MODE_SLA       = 5'd20;
    localparam logic [4:0] MODE_SRA       = 5'd21;
    localparam logic [4:0] MODE_SRL       = 5'd22;
    localparam logic [4:0] MODE_SWAP      = 5'd23;
    localparam logic [4:0] MODE_BIT       = 5'd24;
    localparam logic [4:0] MODE_RES       = 5'd25;
    localparam logic [4:0] MODE_SET       = 5'd26;
    localparam logic [4:0] MODE_DAA       = 5'd27;
    localparam logic [4:0] MODE_LOADFLAGS = 5'd28;

    // decimal adjust constants
    localparam logic [8:0] DAA_ADJ_LO   = 9'h006;
    localparam logic [8:0] DAA_ADJ_HI   = 9'h060;
    localparam logic [8:0] DAA_HI_LIMIT = 9'h09F;

    typedef struct packed {
        logic [4:0]  mode;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
    } t_alu_req;

    typedef struct packed {
        logic [15:0] result;
        logic        zero_flag;
        logic        subtract_flag;
        logic        half_carry_flag;
        logic        carry_flag;
    } t_alu_rsp;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

endpackage

@@ src/cpualu_exec.sv @@
// cpualu_exec: single-pass combinational execute logic with flag update
`timescale 1ns / 1ps

module cpualu_exec (
    input  cpualu_pkg::t_alu_req i_req,
    input  cpualu_pkg::t_flags   i_flags,
    output cpualu_pkg::t_alu_rsp o_rsp,
    output cpualu_pkg::t_flags   o_flags
);
    import cpualu_pkg::*;

    logic [7:0]  w_a;
    logic [7:0]  w_b;
    logic [15:0] w_a16;
    logic [15:0] w_b16;
    logic        w_cin;
    logic        w_add_cin;
    logic        w_sub_cin;
    logic [8:0]  w_add9;
    logic [4:0]  w_add_h5;
    logic [8:0]  w_sub9;
    logic [4:0]  w_sub_h5;
    logic [7:0]  w_inc8;
    logic [7:0]  w_dec8;
    logic [15:0] w_inc16;
    logic [15:0] w_dec16;
    logic [16:0] w_hl17;
    logic [12:0] w_hl_h13;
    logic [15:0] w_sp16;
    logic [4:0]  w_sp_h5;
    logic [8:0]  w_sp_c9;
    logic [7:0]  w_bit_mask;
    logic        w_daa_fix_lo;
    logic        w_daa_fix_hi;
    logic [8:0]  w_daa_t1;
    logic [8:0]  w_daa_add;
    logic [8:0]  w_daa_s1;
    logic [8:0]  w_daa_sub;
    logic [8:0]  w_daa;
    logic [15:0] w_res;
    t_flags      w_nf;

    function automatic logic f_is_zero(input logic [7:0] v);
        return v == 8'h00;
    endfunction

    assign w_a   = i_req.operand_a[7:0];
    assign w_b   = i_req.operand_b[7:0];
    assign w_a16 = i_req.operand_a;
    assign w_b16 = i_req.operand_b;
    assign w_cin = i_flags.c;

    assign w_add_cin = (i_req.mode == MODE_ADC) & w_cin;
    assign w_sub_cin = (i_req.mode == MODE_SBC) & w_cin;

    assign w_add9   = {1'b0, w_a} + {1'b0, w_b} + {8'd0, w_add_cin};
    assign w_add_h5 = {1'b0, w_a[3:0]} + {1'b0, w_b[3:0]} + {4'd0, w_add_cin};
    // bit 8 / bit 4 of the differences act as borrows
    assign w_sub9   = {1'b0, w_a} - {1'b0, w_b} - {8'd0, w_sub_cin};
    assign w_sub_h5 = {1'b0, w_a[3:0]} - {1'b0, w_b[3:0]} - {4'd0, w_sub_cin};

    assign w_inc8  = w_a + 8'd1;
    assign w_dec8  = w_a - 8'd1;
    assign w_inc16 = w_a16 + 16'd1;
    assign w_dec16 = w_a16 - 16'd1;

    assign w_hl17   = {1'b0, w_a16} + {1'b0, w_b16};
    assign w_hl_h13 = {1'b0, w_a16[11:0]} + {1'b0, w_b16[11:0]};

    // signed offset add, flags from unsigned low byte add
    assign w_sp16  = w_a16 + {{8{w_b[7]}}, w_b};
    assign w_sp_h5 = {1'b0, w_a16[3:0]} + {1'b0, w_b[3:0]};
    assign w_sp_c9 = {1'b0, w_a16[7:0]} + {1'b0, w_b};

    assign w_bit_mask = 8'd1 << i_req.bit_index;

    // decimal adjust, add path
    assign w_daa_fix_lo = i_flags.h | (w_a[3:0] > 4'd9);
    assign w_daa_t1     = {1'b0, w_a} + (w_daa_fix_lo ? DAA_ADJ_LO : 9'd0);
    assign w_daa_fix_hi = w_cin | (w_daa_t1 > DAA_HI_LIMIT);
    assign w_daa_add    = w_daa_t1 + (w_daa_fix_hi ? DAA_ADJ_HI : 9'd0);
    // decimal adjust, subtract path (byte wrap, then 9-bit wrap)
    assign w_daa_s1  = i_flags.h ? {1'b0, w_a - DAA_ADJ_LO[7:0]} : {1'b0, w_a};
    assign w_daa_sub = w_cin ? (w_daa_s1 - DAA_ADJ_HI) : w_daa_s1;
    assign w_daa     = i_flags.n ? w_daa_sub : w_daa_add;

    always_comb begin
        w_res = 16'h0000;
        w_nf  = i_flags;
        case (i_req.mode)
            MODE_ADD, MODE_ADC: begin
                w_res = {8'h00, w_add9[7:0]};
                w_nf  = '{z: f_is_zero(w_add9[7:0]), n: 1'b0, h: w_add_h5[4], c: w_add9[8]};
            end
            MODE_SUB, MODE_SBC: begin
                w_res = {8'h00, w_sub9[7:0]};
                w_nf  = '{z: f_is_zero(w_sub9[7:0]), n: 1'b1, h: w_sub_h5[4], c: w_sub9[8]};
            end
            MODE_CP: begin
                w_res = {8'h00, w_a};
                w_nf  = '{z: f_is_zero(w_sub9[7:0]), n: 1'b1, h: w_sub_h5[4], c: w_sub9[8]};
            end
            MODE_AND: begin
                w_res = {8'h00, w_a & w_b};
                w_nf  = '{z: f_is_zero(w_a & w_b), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            MODE_XOR: begin
                w_res = {8'h00, w_a ^ w_b};
                w_nf  = '{z: f_is_zero(w_a ^ w_b), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            MODE_OR: begin
                w_res = {8'h00, w_a | w_b};
                w_nf  = '{z: f_is_zero(w_a | w_b), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            MODE_INC8: begin
                w_res = {8'h00, w_inc8};
                w_nf  = '{z: f_is_zero(w_inc8), n: 1'b0, h: (w_inc8[3:0] == 4'd0), c: w_cin};
            end
            MODE_DEC8: begin
                w_res = {8'h00, w_dec8};
                w_nf  = '{z: f_is_zero(w_dec8), n: 1'b1, h: (w_a[3:0] == 4'd0), c: w_cin};
            end
            MODE_INC16: begin
                w_res = w_inc16;
            end
            MODE_DEC16: begin
                w_res = w_dec16;
            end
            MODE_ADDHL: begin
                w_res = w_hl17[15:0];
                w_nf  = '{z: i_flags.z, n: 1'b0, h: w_hl_h13[12], c: w_hl17[16]};
            end
            MODE_ADDSP: begin
                w_res = w_sp16;
                w_nf  = '{z: 1'b0, n: 1'b0, h: w_sp_h5[4], c: w_sp_c9[8]};
            end
            MODE_RLCA: begin
                w_res = {8'h00, w_a[6:0], w_a[7]};
                w_nf  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: w_a[7]};
            end
            MODE_RRCA: begin
                w_res = {8'h00, w_a[0], w_a[7:1]};
                w_nf  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: w_a[0]};
            end
            MODE_RLC: begin
                w_res = {8'h00, w_a[6:0], w_a[7]};
                w_nf  = '{z: f_is_zero(w_a), n: 1'b0, h: 1'b0, c: w_a[7]};
            end
            MODE_RRC: begin
                w_res = {8'h00, w_a[0], w_a[7:1]};
                w_nf  = '{z: f_is_zero(w_a), n: 1'b0, h: 1'b0, c: w_a[0]};
            end
            MODE_RL: begin
                w_res = {8'h00, w_a[6:0], w_cin};
                w_nf  = '{z: f_is_zero({w_a[6:0], w_cin}), n: 1'b0, h: 1'b0, c: w_a[7]};
            end
            MODE_RR: begin
                w_res = {8'h00, w_cin, w_a[7:1]};
                w_nf  = '{z: f_is_zero({w_cin, w_a[7:1]}), n: 1'b0, h: 1'b0, c: w_a[0]};
            end
            MODE_SLA: begin
                w_res = {8'h00, w_a[6:0], 1'b0};
                w_nf  = '{z: f_is_zero({w_a[6:0], 1'b0}), n: 1'b0, h: 1'b0, c: w_a[7]};
            end
            MODE_SRA: begin
                w_res = {8'h00, w_a[7], w_a[7:1]};
                w_nf  = '{z: f_is_zero({w_a[7], w_a[7:1]}), n: 1'b0, h: 1'b0, c: w_a[0]};
            end
            MODE_SRL: begin
                w_res = {8'h00, 1'b0, w_a[7:1]};
                w_nf  = '{z: f_is_zero({1'b0, w_a[7:1]}), n: 1'b0, h: 1'b0, c: w_a[0]};
            end
            MODE_SWAP: begin
                w_res = {8'h00, w_a[3:0], w_a[7:4]};
                w_nf  = '{z: f_is_zero(w_a), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            MODE_BIT: begin
                w_res = {8'h00, w_a};
                w_nf  = '{z: ~w_a[i_req.bit_index], n: 1'b0, h: 1'b1, c: i_flags.c};
            end
            MODE_RES: begin
                w_res = {8'h00, w_a & ~w_bit_mask};
            end
            MODE_SET: begin
                w_res = {8'h00, w_a | w_bit_mask};
            end
            MODE_DAA: begin
                // carry is sticky, n is kept
                w_res = {8'h00, w_daa[7:0]};
                w_nf  = '{z: f_is_zero(w_daa[7:0]), n: i_flags.n, h: 1'b0,
                          c: w_cin | w_daa[8]};
            end
            MODE_LOADFLAGS: begin
                w_res = {8'h00, w_b[7:4], 4'h0};
                w_nf  = '{z: w_b[7], n: w_b[6], h: w_b[5], c: w_b[4]};
            end
            default: begin
                // unused codes: zero result, flags untouched
                w_res = 16'h0000;
                w_nf  = i_flags;
            end
        endcase
    end

    assign o_rsp.result          = w_res;
    assign o_rsp.zero_flag       = w_nf.z;
    assign o_rsp.subtract_flag   = w_nf.n;
    assign o_rsp.half_carry_flag = w_nf.h;
    assign o_rsp.carry_flag      = w_nf.c;
    assign o_flags               = w_nf;

endmodule

@@ src/cpu_alu_with_flags.sv @@
// cpu_alu_with_flags: 8/16-bit cpu alu with persistent z/n/h/c flags, top level
//
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-----------------------
// request   | in        | i_req_valid / o_req_stall  | i_req (t_alu_req)
// response  | out       | o_rsp_valid / i_rsp_stall  | o_rsp (t_alu_rsp)
//
// one request per cycle while the response channel is not stalled; a request passes
// from accept to response valid through input register, execute logic, response register
// the rate is set by the flag register loop, a single pass through the exec unit
// reset (i_rst_n low, synchronous) empties both stages and clears z, n, h, c
// a stalled response holds; the input register keeps taking requests as long as it
// is empty or the response register is empty or being drained in the same cycle
`timescale 1ns / 1ps

module cpu_alu_with_flags (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_stall,
    input  cpualu_pkg::t_alu_req i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_stall,
    output cpualu_pkg::t_alu_rsp o_rsp
);
    import cpualu_pkg::*;

    // input stage
    logic     r_s1_valid;
    t_alu_req r_s1_req;
    // response stage
    logic     r_s2_valid;
    t_alu_rsp r_rsp;
    // architectural flags
    t_flags   r_flags;

    logic     w_s2_free;
    logic     w_adv;
    logic     w_req_take;
    t_alu_rsp w_exec_rsp;
    t_flags   w_exec_flags;

    // response register can load when empty or emptied this cycle
    assign w_s2_free  = ~r_s2_valid | ~i_rsp_stall;
    // request in the input stage moves through execute into the response register
    assign w_adv      = r_s1_valid & w_s2_free;
    // input stage holds only while its request is blocked downstream
    assign o_req_stall = r_s1_valid & ~w_s2_free;
    assign w_req_take  = i_req_valid & ~o_req_stall;

    cpualu_exec u_exec (
        .i_req   (r_s1_req),
        .i_flags (r_flags),
        .o_rsp   (w_exec_rsp),
        .o_flags (w_exec_flags)
    );

    // control state and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_flags    <= '0;
        end else begin
            if (!r_s1_valid || w_s2_free) begin
                r_s1_valid <= i_req_valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            // flags commit together with the response
            if (w_adv) begin
                r_flags <= w_exec_flags;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_req_take) begin
            r_s1_req <= i_req;
        end
        if (w_adv) begin
            r_rsp <= w_exec_rsp;
        end
    end

    assign o_rsp_valid = r_s2_valid;
    assign o_rsp       = r_rsp;

    // flags only move when a request is executed
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> r_flags == $past(r_flags))
        else $error("flags changed without an executed request");

    // a pending response always carries the current flag state
    a_rsp_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.zero_flag == r_flags.z && o_rsp.subtract_flag == r_flags.n
                         && o_rsp.half_carry_flag == r_flags.h
                         && o_rsp.carry_flag == r_flags.c))
        else $error("response flags differ from flag state");

    // a blocked request in the input stage is neither lost nor overwritten
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s2_free) |=> (r_s1_valid && $stable(r_s1_req)))
        else $error("blocked request in input stage lost");

endmodule
